/* rtl/core/layered_ellipse_face_pixel_generator_top_macros.svh */
// Assertion macros shared by the face pixel generator RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef LAYERED_ELLIPSE_FACE_PIXEL_GENERATOR_TOP_MACROS_SVH
`define LAYERED_ELLIPSE_FACE_PIXEL_GENERATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LEFPG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LEFPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lefpg_pkg.sv */
// Package for the face pixel generator: widths, geometry, palette and stage payloads.
// It also holds the elaboration-time builder of the moustache and brow span tables.
package lefpg_pkg;

  localparam int unsigned LOGICAL_WIDTH  = 160;
  localparam int unsigned LOGICAL_HEIGHT = 120;

  localparam int unsigned COL_W   = 8;
  localparam int unsigned ROW_W   = 7;
  localparam int unsigned MH_W    = 4;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned SQ_W    = 16;
  localparam int unsigned RSQ_W   = 12;
  localparam int unsigned MR_W    = 3;
  localparam int unsigned MR2_W   = 6;
  localparam int unsigned SPAN_W  = 8;

  localparam int MID            = 80;
  localparam int FACE_RX        = 33;
  localparam int FACE_RY        = 45;
  localparam int MOUTH_BASE_ROW = 88;
  localparam int MOUTH_HALF_W   = 9;
  localparam int EYE_L_X        = 66;
  localparam int EYE_R_X        = 94;

  localparam logic [SPAN_W-1:0] SPAN_EMPTY = 8'd255;

  typedef enum logic [0:0] {
    CURVE_MOUSTACHE = 1'b0,
    CURVE_BROW      = 1'b1
  } curve_e;

  function automatic logic [COLOR_W-1:0] rgb565(int r, int g, int b);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = 5'(r >> 3);
    g6 = 6'(g >> 2);
    b5 = 5'(b >> 3);
    return {r5, g6, b5};
  endfunction

  localparam logic [COLOR_W-1:0] COLOR_BG      = rgb565(10, 9, 11);
  localparam logic [COLOR_W-1:0] COLOR_HOOD    = rgb565(168, 26, 32);
  localparam logic [COLOR_W-1:0] COLOR_HOOD_DK = rgb565(108, 16, 21);
  localparam logic [COLOR_W-1:0] COLOR_SKIN    = rgb565(232, 197, 152);
  localparam logic [COLOR_W-1:0] COLOR_SHADE   = rgb565(206, 168, 122);
  localparam logic [COLOR_W-1:0] COLOR_INK     = rgb565(18, 15, 17);
  localparam logic [COLOR_W-1:0] COLOR_LIGHT   = rgb565(245, 242, 236);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [MR2_W-1:0] mr2;
    logic [SQ_W-1:0]  sx_mid;
    logic [SQ_W-1:0]  sx_l_hi;
    logic [SQ_W-1:0]  sx_l;
    logic [SQ_W-1:0]  sx_r_hi;
    logic [SQ_W-1:0]  sx_r;
    logic [SQ_W-1:0]  sy_mouth;
    logic [SQ_W-1:0]  sy_54;
    logic [SQ_W-1:0]  sy_56;
    logic [SQ_W-1:0]  sy_74;
    logic [SQ_W-1:0]  sy_17;
    logic [SQ_W-1:0]  sy_97;
    logic [SQ_W-1:0]  sy_57;
    logic [SQ_W-1:0]  sy_60;
  } dist_t;

  typedef struct packed {
    logic mouth;
    logic moustache;
    logic l_hi;
    logic l_pupil;
    logic l_white;
    logic r_hi;
    logic r_pupil;
    logic r_white;
    logic brow;
    logic nose;
    logic nose_line;
    logic face;
    logic face_top;
    logic face_bot;
    logic hood_dk;
    logic hood;
  } hit_t;

  // Squared distance between two 8-bit coordinates.
  function automatic logic [SQ_W-1:0] sq_dist(logic [7:0] v, logic [7:0] c);
    logic [7:0] d;
    d = (v >= c) ? (v - c) : (c - v);
    return SQ_W'({8'd0, d} * {8'd0, d});
  endfunction

  // Exact ellipse test: dx^2*ry^2 + dy^2*rx^2 <= rx^2*ry^2.
  function automatic logic ell_hit(logic [SQ_W-1:0] dx2, logic [SQ_W-1:0] dy2,
                                   logic [RSQ_W-1:0] rx2, logic [RSQ_W-1:0] ry2);
    logic [27:0] px;
    logic [27:0] py;
    logic [27:0] pr;
    logic [28:0] lhs;
    px  = {12'd0, dx2} * {16'd0, ry2};
    py  = {12'd0, dy2} * {16'd0, rx2};
    pr  = {16'd0, rx2} * {16'd0, ry2};
    lhs = {1'b0, px} + {1'b0, py};
    return lhs <= {1'b0, pr};
  endfunction

  // Top row (upper byte) and bottom row (lower byte) of one column's curve span.
  function automatic logic [2*SPAN_W-1:0] curve_span(int c, int w, int h, curve_e kind);
    int top;
    int bot;
    int x;
    int y;
    int n;
    int lo;
    int hi;
    int s;
    int i;
    top = 255;
    bot = 0;
    n   = (kind == CURVE_BROW) ? 20 : 48;
    for (s = -1; s <= 1; s += 2) begin
      for (i = 0; i <= n; i++) begin
        if (kind == CURVE_BROW) begin
          x = MID + s * (7 + (4 * i) / 5);
          y = (8800 - 50 * i + 9 * (i - 8) * (i - 8)) / 200;
        end else begin
          x = MID + s * ((13 * i) / 24);
          y = (1474560 + i * i * (232 - 7 * i)) / 18432;
        end
        lo = y - 2;
        hi = y + 2;
        if (lo < 0) lo = 0;
        if (hi > h - 1) hi = h - 1;
        if (c >= x - 2 && c <= x + 2 && c < w) begin
          if (lo < top) top = lo;
          if (hi > bot) bot = hi;
        end
      end
    end
    return {SPAN_W'(top), SPAN_W'(bot)};
  endfunction

endpackage

/* rtl/core/lefpg_in_if.sv */
// Input channel of the face pixel generator: one pixel coordinate and mouth height per beat.
// Depends on lefpg_pkg for the field widths.
interface lefpg_in_if;
  logic                           valid;
  logic                           ready;
  logic [lefpg_pkg::COL_W-1:0]    col;
  logic [lefpg_pkg::ROW_W-1:0]    row;
  logic [lefpg_pkg::MH_W-1:0]     mouth_height;

  modport source (output valid, output col, output row, output mouth_height, input ready);
  modport sink (input valid, input col, input row, input mouth_height, output ready);
endinterface

/* rtl/core/lefpg_out_if.sv */
// Output channel of the face pixel generator: one RGB565 color per beat.
// Depends on lefpg_pkg for the color width.
interface lefpg_out_if;
  logic                           valid;
  logic                           ready;
  logic [lefpg_pkg::COLOR_W-1:0]  color;

  modport source (output valid, output color, input ready);
  modport sink (input valid, input color, output ready);
endinterface

/* rtl/core/lefpg_dist.sv */
// First pipeline stage: mouth radius and squared distances to every fixed center and to the mouth center.
// Depends on lefpg_pkg and the shared assertion macros.
`include "layered_ellipse_face_pixel_generator_top_macros.svh"

module lefpg_dist (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [lefpg_pkg::COL_W-1:0]  col_i,
  input  logic [lefpg_pkg::ROW_W-1:0]  row_i,
  input  logic [lefpg_pkg::MH_W-1:0]   mouth_height_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output lefpg_pkg::dist_t             dist_o
);

  logic                          valid_q;
  lefpg_pkg::dist_t              dist_d;
  lefpg_pkg::dist_t              dist_q;
  logic [lefpg_pkg::MR_W-1:0]    mr;
  logic [7:0]                    row8;
  logic [7:0]                    mouth_row;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    mr        = (mouth_height_i[3:1] == 3'd0) ? 3'd1 : mouth_height_i[3:1];
    row8      = {1'b0, row_i};
    mouth_row = 8'(lefpg_pkg::MOUTH_BASE_ROW) + {5'd0, mr};

    dist_d.col      = col_i;
    dist_d.row      = row_i;
    dist_d.mr2      = lefpg_pkg::MR2_W'({3'd0, mr} * {3'd0, mr});
    dist_d.sx_mid   = lefpg_pkg::sq_dist(col_i, 8'(lefpg_pkg::MID));
    dist_d.sx_l_hi  = lefpg_pkg::sq_dist(col_i, 8'(lefpg_pkg::EYE_L_X - 1));
    dist_d.sx_l     = lefpg_pkg::sq_dist(col_i, 8'(lefpg_pkg::EYE_L_X));
    dist_d.sx_r_hi  = lefpg_pkg::sq_dist(col_i, 8'(lefpg_pkg::EYE_R_X - 1));
    dist_d.sx_r     = lefpg_pkg::sq_dist(col_i, 8'(lefpg_pkg::EYE_R_X));
    dist_d.sy_mouth = lefpg_pkg::sq_dist(row8, mouth_row);
    dist_d.sy_54    = lefpg_pkg::sq_dist(row8, 8'd54);
    dist_d.sy_56    = lefpg_pkg::sq_dist(row8, 8'd56);
    dist_d.sy_74    = lefpg_pkg::sq_dist(row8, 8'd74);
    dist_d.sy_17    = lefpg_pkg::sq_dist(row8, 8'd17);
    dist_d.sy_97    = lefpg_pkg::sq_dist(row8, 8'd97);
    dist_d.sy_57    = lefpg_pkg::sq_dist(row8, 8'd57);
    dist_d.sy_60    = lefpg_pkg::sq_dist(row8, 8'd60);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      dist_q <= dist_d;
    end
  end

  assign valid_o = valid_q;
  assign dist_o  = dist_q;

  `LEFPG_ASSERT_NEXT(a_dist_takes_beat, valid_i && ready_o, valid_o, "accepted beat missing in stage one")

endmodule

/* rtl/core/lefpg_hit.sv */
// Second pipeline stage: ellipse tests, span table lookups and band tests per layer.
// Depends on lefpg_pkg and the shared assertion macros.
`include "layered_ellipse_face_pixel_generator_top_macros.svh"

module lefpg_hit #(
  parameter int unsigned LOGICAL_WIDTH  = lefpg_pkg::LOGICAL_WIDTH,
  parameter int unsigned LOGICAL_HEIGHT = lefpg_pkg::LOGICAL_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  lefpg_pkg::dist_t  dist_i,
  output logic              valid_o,
  input  logic              ready_i,
  output lefpg_pkg::hit_t   hit_o
);

  localparam int unsigned IDX_W     = $clog2(LOGICAL_WIDTH);
  localparam int unsigned TAB_DEPTH = 2 ** IDX_W;

  logic [lefpg_pkg::SPAN_W-1:0] mt_tab [TAB_DEPTH];
  logic [lefpg_pkg::SPAN_W-1:0] mb_tab [TAB_DEPTH];
  logic [lefpg_pkg::SPAN_W-1:0] bt_tab [TAB_DEPTH];
  logic [lefpg_pkg::SPAN_W-1:0] bb_tab [TAB_DEPTH];

  for (genvar c = 0; c < TAB_DEPTH; c++) begin : g_col
    localparam logic [2*lefpg_pkg::SPAN_W-1:0] MSPAN =
      lefpg_pkg::curve_span(c, LOGICAL_WIDTH, LOGICAL_HEIGHT, lefpg_pkg::CURVE_MOUSTACHE);
    localparam logic [2*lefpg_pkg::SPAN_W-1:0] BSPAN =
      lefpg_pkg::curve_span(c, LOGICAL_WIDTH, LOGICAL_HEIGHT, lefpg_pkg::CURVE_BROW);
    assign mt_tab[c] = MSPAN[2*lefpg_pkg::SPAN_W-1:lefpg_pkg::SPAN_W];
    assign mb_tab[c] = MSPAN[lefpg_pkg::SPAN_W-1:0];
    assign bt_tab[c] = BSPAN[2*lefpg_pkg::SPAN_W-1:lefpg_pkg::SPAN_W];
    assign bb_tab[c] = BSPAN[lefpg_pkg::SPAN_W-1:0];
  end

  logic                         valid_q;
  lefpg_pkg::hit_t              hit_d;
  lefpg_pkg::hit_t              hit_q;
  logic [IDX_W-1:0]             idx;
  logic [lefpg_pkg::SPAN_W-1:0] mt;
  logic [lefpg_pkg::SPAN_W-1:0] mb;
  logic [lefpg_pkg::SPAN_W-1:0] bt;
  logic [lefpg_pkg::SPAN_W-1:0] bb;
  logic [7:0]                   row8;
  logic [7:0]                   col8;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    idx  = dist_i.col[IDX_W-1:0];
    mt   = mt_tab[idx];
    mb   = mb_tab[idx];
    bt   = bt_tab[idx];
    bb   = bb_tab[idx];
    row8 = {1'b0, dist_i.row};
    col8 = dist_i.col;

    hit_d.mouth     = lefpg_pkg::ell_hit(dist_i.sx_mid, dist_i.sy_mouth,
                        12'(lefpg_pkg::MOUTH_HALF_W * lefpg_pkg::MOUTH_HALF_W),
                        lefpg_pkg::RSQ_W'(dist_i.mr2));
    hit_d.moustache = (mt != lefpg_pkg::SPAN_EMPTY) && (row8 >= mt) && (row8 <= mb);
    hit_d.l_hi      = lefpg_pkg::ell_hit(dist_i.sx_l_hi, dist_i.sy_54, 12'd1, 12'd1);
    hit_d.l_pupil   = lefpg_pkg::ell_hit(dist_i.sx_l, dist_i.sy_56, 12'd16, 12'd16);
    hit_d.l_white   = lefpg_pkg::ell_hit(dist_i.sx_l, dist_i.sy_56, 12'd64, 12'd81);
    hit_d.r_hi      = lefpg_pkg::ell_hit(dist_i.sx_r_hi, dist_i.sy_54, 12'd1, 12'd1);
    hit_d.r_pupil   = lefpg_pkg::ell_hit(dist_i.sx_r, dist_i.sy_56, 12'd16, 12'd16);
    hit_d.r_white   = lefpg_pkg::ell_hit(dist_i.sx_r, dist_i.sy_56, 12'd64, 12'd81);
    hit_d.brow      = (bt != lefpg_pkg::SPAN_EMPTY) && (row8 >= bt) && (row8 <= bb);
    hit_d.nose      = lefpg_pkg::ell_hit(dist_i.sx_mid, dist_i.sy_74, 12'd25, 12'd9);
    hit_d.nose_line = ((col8 == 8'(lefpg_pkg::MID - 3)) || (col8 == 8'(lefpg_pkg::MID + 3)))
                      && (row8 >= 8'd60) && (row8 <= 8'd73);
    hit_d.face      = lefpg_pkg::ell_hit(dist_i.sx_mid, dist_i.sy_56,
                        12'(lefpg_pkg::FACE_RX * lefpg_pkg::FACE_RX),
                        12'(lefpg_pkg::FACE_RY * lefpg_pkg::FACE_RY));
    hit_d.face_top  = lefpg_pkg::ell_hit(dist_i.sx_mid, dist_i.sy_17,
                        12'(lefpg_pkg::FACE_RX * lefpg_pkg::FACE_RX), 12'd144);
    hit_d.face_bot  = lefpg_pkg::ell_hit(dist_i.sx_mid, dist_i.sy_97, 12'd841, 12'd196);
    hit_d.hood_dk   = lefpg_pkg::ell_hit(dist_i.sx_mid, dist_i.sy_57, 12'd1296, 12'd2304)
                      || ((row8 > 8'd57) && (col8 >= 8'(lefpg_pkg::MID - 36))
                          && (col8 <= 8'(lefpg_pkg::MID + 36)));
    hit_d.hood      = lefpg_pkg::ell_hit(dist_i.sx_mid, dist_i.sy_60, 12'd2704, 12'd3364)
                      || ((row8 > 8'd60) && (col8 >= 8'(lefpg_pkg::MID - 52))
                          && (col8 <= 8'(lefpg_pkg::MID + 52)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;

  `LEFPG_ASSERT_SAME(a_eyes_disjoint, valid_o, $onehot0({hit_o.l_hi | hit_o.l_pupil | hit_o.l_white, hit_o.r_hi | hit_o.r_pupil | hit_o.r_white}), "pixel hits both eyes")

endmodule

/* rtl/core/lefpg_shade.sv */
// Third pipeline stage: front-to-back layer priority and the registered output color.
// Depends on lefpg_pkg and the shared assertion macros.
`include "layered_ellipse_face_pixel_generator_top_macros.svh"

module lefpg_shade (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  lefpg_pkg::hit_t                hit_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [lefpg_pkg::COLOR_W-1:0]  color_o
);

  logic                          valid_q;
  logic [lefpg_pkg::COLOR_W-1:0] color_d;
  logic [lefpg_pkg::COLOR_W-1:0] color_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    if (hit_i.mouth || hit_i.moustache) begin
      color_d = lefpg_pkg::COLOR_INK;
    end else if (hit_i.l_hi) begin
      color_d = lefpg_pkg::COLOR_LIGHT;
    end else if (hit_i.l_pupil) begin
      color_d = lefpg_pkg::COLOR_INK;
    end else if (hit_i.l_white || hit_i.r_hi) begin
      color_d = lefpg_pkg::COLOR_LIGHT;
    end else if (hit_i.r_pupil) begin
      color_d = lefpg_pkg::COLOR_INK;
    end else if (hit_i.r_white) begin
      color_d = lefpg_pkg::COLOR_LIGHT;
    end else if (hit_i.brow) begin
      color_d = lefpg_pkg::COLOR_INK;
    end else if (hit_i.nose || hit_i.nose_line) begin
      color_d = lefpg_pkg::COLOR_SHADE;
    end else if (hit_i.face) begin
      color_d = (hit_i.face_top || hit_i.face_bot) ? lefpg_pkg::COLOR_SHADE
                                                   : lefpg_pkg::COLOR_SKIN;
    end else if (hit_i.hood_dk) begin
      color_d = lefpg_pkg::COLOR_HOOD_DK;
    end else if (hit_i.hood) begin
      color_d = lefpg_pkg::COLOR_HOOD;
    end else begin
      color_d = lefpg_pkg::COLOR_BG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      color_q <= color_d;
    end
  end

  assign valid_o = valid_q;
  assign color_o = color_q;

  `LEFPG_ASSERT_SAME(a_color_in_palette, valid_o, (color_o == lefpg_pkg::COLOR_BG) || (color_o == lefpg_pkg::COLOR_HOOD) || (color_o == lefpg_pkg::COLOR_HOOD_DK) || (color_o == lefpg_pkg::COLOR_SKIN) || (color_o == lefpg_pkg::COLOR_SHADE) || (color_o == lefpg_pkg::COLOR_INK) || (color_o == lefpg_pkg::COLOR_LIGHT), "output color outside the palette")

endmodule

/* rtl/core/layered_ellipse_face_pixel_generator_top.sv */
// Face pixel generator: takes one pixel coordinate and mouth height per beat and returns
// its RGB565 color. A new pixel is accepted every clock; the rate is set by the
// three-stage pipeline (squared distances, layer tests with span table lookups,
// priority select), whose registers the pixel passes in that order and which stalls
// only under output backpressure.
// The span tables are constant logic, so no clearing pass follows reset.
`include "layered_ellipse_face_pixel_generator_top_macros.svh"

module layered_ellipse_face_pixel_generator_top #(
  parameter int unsigned LOGICAL_WIDTH  = lefpg_pkg::LOGICAL_WIDTH,
  parameter int unsigned LOGICAL_HEIGHT = lefpg_pkg::LOGICAL_HEIGHT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lefpg_in_if.sink     pix_i,
  lefpg_out_if.source  pix_o
);

  logic             dist_valid;
  logic             dist_ready;
  lefpg_pkg::dist_t sq_data;
  logic             hit_valid;
  logic             hit_ready;
  lefpg_pkg::hit_t  hit;

  lefpg_dist u_dist (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (pix_i.valid),
    .ready_o        (pix_i.ready),
    .col_i          (pix_i.col),
    .row_i          (pix_i.row),
    .mouth_height_i (pix_i.mouth_height),
    .valid_o        (dist_valid),
    .ready_i        (dist_ready),
    .dist_o         (sq_data)
  );

  lefpg_hit #(
    .LOGICAL_WIDTH  (LOGICAL_WIDTH),
    .LOGICAL_HEIGHT (LOGICAL_HEIGHT)
  ) u_hit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dist_valid),
    .ready_o (dist_ready),
    .dist_i  (sq_data),
    .valid_o (hit_valid),
    .ready_i (hit_ready),
    .hit_o   (hit)
  );

  lefpg_shade u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hit_valid),
    .ready_o (hit_ready),
    .hit_i   (hit),
    .valid_o (pix_o.valid),
    .ready_i (pix_o.ready),
    .color_o (pix_o.color)
  );

  `LEFPG_ASSERT_SAME(a_stall_only_on_backpressure, !pix_i.ready, pix_o.valid && !pix_o.ready, "input stalled without output backpressure")
  `LEFPG_ASSERT_SAME(a_full_pipe_on_stall, !pix_i.ready, dist_valid && hit_valid, "input stalled with a bubble in the pipeline")

endmodule
